>>> design/mhe_pkg.sv
package mhe_pkg;

  localparam int CapacityDef = 1024;
  localparam int DataW       = 32;
  localparam int CountOutW   = 11;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_LAST,
    S_CHK,
    S_LEFT,
    S_RIGHT,
    S_DEC
  } state_e;

endpackage

>>> design/mhe_ram.sv
module mhe_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/mhe_cmp.sv
// shared unsigned less-than unit
module mhe_cmp (
  input  logic [mhe_pkg::DataW-1:0] a_i,
  input  logic [mhe_pkg::DataW-1:0] b_i,
  output logic                      lt_o
);

  assign lt_o = (a_i < b_i);

endmodule

>>> design/min_heap_extract_core.sv
// channel   | signals                                  | transfer
// ----------+------------------------------------------+------------------------------
// command   | start, busy, op_i, value_i               | start high while busy low
// result    | done_o, popped_value_o, status_o,        | one cycle, marked by done_o
//           | count_after_o                            |
//
// Load and failed pops finish in idle; result shows on the next cycle, busy stays low.
// A pop holds busy over root and last-word reads, then per level a child check, child
// reads and a compare-write, until no child is left, a compare stops it, or the root
// read empties the heap. Result shows as busy drops; one RAM read port, one comparator.
// Reset clears the live count and the sequencer; heap words are undefined until loaded.
// Results cannot be stalled: each transaction appears for exactly one cycle.
module min_heap_extract_core #(
  parameter int CAPACITY = mhe_pkg::CapacityDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op_i,
  input  logic [mhe_pkg::DataW-1:0]     value_i,
  output logic                          done_o,
  output logic [mhe_pkg::DataW-1:0]     popped_value_o,
  output logic [1:0]                    status_o,
  output logic [mhe_pkg::CountOutW-1:0] count_after_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  mhe_pkg::state_e  state_q, state_d;
  mhe_pkg::status_e status_q, status_d;

  logic [CW-1:0]             count_q, count_d;
  logic [AW-1:0]             pos_q, pos_d;
  logic [AW-1:0]             cidx_q, cidx_d;
  logic [mhe_pkg::DataW-1:0] x_q, x_d;
  logic [mhe_pkg::DataW-1:0] l_q, l_d;
  logic [mhe_pkg::DataW-1:0] cval_q, cval_d;
  logic [mhe_pkg::DataW-1:0] popped_q, popped_d;
  logic                      strobe_q, strobe_d;

  logic                      we;
  logic [AW-1:0]             waddr, raddr;
  logic [mhe_pkg::DataW-1:0] wdata, rdata;
  logic [mhe_pkg::DataW-1:0] cmp_a, cmp_b;
  logic                      cmp_lt;

  logic [IW-1:0] left_w, right_w, n_ext;
  logic          left_out, right_in, full, accept;

  assign left_w   = {1'b0, pos_q, 1'b1};
  assign right_w  = IW'(left_w + IW'(1));
  assign n_ext    = IW'(count_q);
  assign left_out = (left_w >= n_ext);
  assign right_in = (right_w < n_ext);
  assign full     = (count_q == CW'(CAPACITY));
  assign busy     = (state_q != mhe_pkg::S_IDLE);
  assign accept   = start && !busy;

  mhe_ram #(
    .Width (mhe_pkg::DataW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mhe_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .lt_o (cmp_lt)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      mhe_pkg::S_IDLE: begin
        if (accept && op_i == mhe_pkg::OP_POP && count_q != '0) begin
          state_d = mhe_pkg::S_ROOT;
        end
      end
      mhe_pkg::S_ROOT: begin
        state_d = (count_q == '0) ? mhe_pkg::S_IDLE : mhe_pkg::S_LAST;
      end
      mhe_pkg::S_LAST:  state_d = mhe_pkg::S_CHK;
      mhe_pkg::S_CHK: begin
        state_d = left_out ? mhe_pkg::S_IDLE : mhe_pkg::S_LEFT;
      end
      mhe_pkg::S_LEFT: begin
        state_d = right_in ? mhe_pkg::S_RIGHT : mhe_pkg::S_DEC;
      end
      mhe_pkg::S_RIGHT: state_d = mhe_pkg::S_DEC;
      mhe_pkg::S_DEC: begin
        state_d = cmp_lt ? mhe_pkg::S_CHK : mhe_pkg::S_IDLE;
      end
      default: state_d = mhe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    count_d  = count_q;
    pos_d    = pos_q;
    cidx_d   = cidx_q;
    x_d      = x_q;
    l_d      = l_q;
    cval_d   = cval_q;
    popped_d = popped_q;
    status_d = status_q;
    strobe_d = 1'b0;
    we       = 1'b0;
    waddr    = pos_q;
    wdata    = x_q;
    raddr    = '0;
    cmp_a    = cval_q;
    cmp_b    = x_q;
    case (state_q)
      mhe_pkg::S_IDLE: begin
        if (accept) begin
          if (op_i == mhe_pkg::OP_LOAD) begin
            strobe_d = 1'b1;
            popped_d = '0;
            if (full) begin
              status_d = mhe_pkg::ST_FULL;
            end else begin
              status_d = mhe_pkg::ST_OK;
              we       = 1'b1;
              waddr    = count_q[AW-1:0];
              wdata    = value_i;
              count_d  = CW'(count_q + CW'(1));
            end
          end else if (count_q == '0) begin
            strobe_d = 1'b1;
            popped_d = '0;
            status_d = mhe_pkg::ST_EMPTY;
          end else begin
            raddr   = '0;
            count_d = CW'(count_q - CW'(1));
          end
        end
      end
      mhe_pkg::S_ROOT: begin
        popped_d = rdata;
        raddr    = count_q[AW-1:0];
        if (count_q == '0) begin
          strobe_d = 1'b1;
          status_d = mhe_pkg::ST_OK;
        end
      end
      mhe_pkg::S_LAST: begin
        x_d   = rdata;
        pos_d = '0;
      end
      mhe_pkg::S_CHK: begin
        raddr = left_w[AW-1:0];
        if (left_out) begin
          we       = 1'b1;
          wdata    = x_q;
          strobe_d = 1'b1;
          status_d = mhe_pkg::ST_OK;
        end
      end
      mhe_pkg::S_LEFT: begin
        l_d    = rdata;
        cval_d = rdata;
        cidx_d = left_w[AW-1:0];
        raddr  = right_w[AW-1:0];
      end
      mhe_pkg::S_RIGHT: begin
        cmp_a = rdata;
        cmp_b = l_q;
        if (cmp_lt) begin
          cval_d = rdata;
          cidx_d = right_w[AW-1:0];
        end
      end
      mhe_pkg::S_DEC: begin
        we = 1'b1;
        if (cmp_lt) begin
          wdata = cval_q;
          pos_d = cidx_q;
        end else begin
          wdata    = x_q;
          strobe_d = 1'b1;
          status_d = mhe_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mhe_pkg::S_IDLE;
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    cidx_q   <= cidx_d;
    x_q      <= x_d;
    l_q      <= l_d;
    cval_q   <= cval_d;
    popped_q <= popped_d;
    status_q <= status_d;
  end

  assign done_o         = strobe_q;
  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign count_after_o  = mhe_pkg::CountOutW'(count_q);

endmodule

>>> dv/min_heap_extract_checker.sv
module min_heap_extract_checker #(
  parameter int CAPACITY = mhe_pkg::CapacityDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          op_i,
  input  logic [mhe_pkg::DataW-1:0]     value_i,
  input  logic                          done_o,
  input  logic [mhe_pkg::DataW-1:0]     popped_value_o,
  input  logic [1:0]                    status_o,
  input  logic [mhe_pkg::CountOutW-1:0] count_after_o,
  output int                            fail_count_o,
  output int                            pending_o
);
  import mhe_pkg::*;

  typedef struct packed {
    logic [DataW-1:0]     popped;
    status_e              status;
    logic [CountOutW-1:0] count;
  } heap_result_t;

  logic [DataW-1:0] heap_words [CAPACITY];
  int unsigned      live_n = 0;
  heap_result_t     awaited_q [$];
  int               fail_n = 0;

  function automatic heap_result_t apply_transaction(logic op, logic [DataW-1:0] value);
    heap_result_t     res;
    int unsigned      pos;
    int unsigned      pick;
    int unsigned      lhs;
    int unsigned      rhs;
    logic [DataW-1:0] tmp;
    res = '{popped: '0, status: ST_OK, count: '0};
    if (op == OP_LOAD) begin
      if (live_n >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        heap_words[live_n] = value;
        live_n++;
      end
    end else if (live_n == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.popped = heap_words[0];
      live_n--;
      heap_words[0] = heap_words[live_n];
      pick = 0;
      do begin
        pos = pick;
        lhs = 2 * pos + 1;
        rhs = 2 * pos + 2;
        if (lhs < live_n && heap_words[lhs] < heap_words[pick]) pick = lhs;
        if (rhs < live_n && heap_words[rhs] < heap_words[pick]) pick = rhs;
        if (pick != pos) begin
          tmp              = heap_words[pos];
          heap_words[pos]  = heap_words[pick];
          heap_words[pick] = tmp;
        end
      end while (pick != pos);
    end
    res.count = CountOutW'(live_n);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t due;
    if (!rst_ni) begin
      awaited_q.delete();
      live_n = 0;
    end else begin
      if (done_o) begin
        if (awaited_q.size() == 0) begin
          $error("result transaction with none awaiting it");
          fail_n++;
        end else begin
          due = awaited_q.pop_front();
          if (popped_value_o !== due.popped) begin
            $error("popped_value: expected %0h, got %0h", due.popped, popped_value_o);
            fail_n++;
          end
          if (status_o !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, status_o);
            fail_n++;
          end
          if (count_after_o !== due.count) begin
            $error("count_after: expected %0d, got %0d", due.count, count_after_o);
            fail_n++;
          end
        end
      end
      if (start && !busy) awaited_q.push_back(apply_transaction(op_i, value_i));
    end
    fail_count_o <= fail_n;
    pending_o    <= awaited_q.size();
  end

endmodule

>>> dv/testbench.sv
module testbench;
  import mhe_pkg::*;

  localparam int HeapCap    = CapacityDef;
  localparam int PhaseItems = 233;
  localparam int CycleLimit = 1000000;
  localparam int IdleMix [3] = '{33, 78, 0};

  localparam logic [DataW:0] DirectedScript [25] = '{
    {OP_POP,  32'h0000_0000}, {OP_LOAD, 32'h0000_0000}, {OP_LOAD, 32'hFFFF_FFFF},
    {OP_POP,  32'hFFFF_FFFF}, {OP_POP,  32'h0000_0000}, {OP_POP,  32'hA5A5_A5A5},
    {OP_LOAD, 32'd1}, {OP_LOAD, 32'd5}, {OP_LOAD, 32'd2}, {OP_LOAD, 32'd8},
    {OP_POP,  32'h0}, {OP_POP,  32'h0}, {OP_POP,  32'h0}, {OP_POP,  32'h0},
    {OP_LOAD, 32'd1}, {OP_LOAD, 32'd4}, {OP_LOAD, 32'd4}, {OP_LOAD, 32'd9},
    {OP_LOAD, 32'd9}, {OP_POP,  32'h0}, {OP_LOAD, 32'd3},
    {OP_POP,  32'h0}, {OP_POP,  32'h0}, {OP_POP,  32'h0}, {OP_POP,  32'h0}
  };

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 start   = 1'b0;
  logic                 op_i    = OP_LOAD;
  logic [DataW-1:0]     value_i = '0;
  logic                 busy;
  logic                 done_o;
  logic [DataW-1:0]     popped_value_o;
  logic [1:0]           status_o;
  logic [CountOutW-1:0] count_after_o;
  int                   fail_count;
  int                   pending_n;

  int          cycle_n   = 0;
  int          idle_pct  = 0;
  int unsigned occupancy = 0;
  logic [DataW-1:0] ceiling = '0;
  int n_items = 0;
  int n_loads = 0;
  int n_pops  = 0;
  int n_full  = 0;
  int n_empty = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  min_heap_extract_core #(.CAPACITY(HeapCap)) dut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .value_i,
    .done_o, .popped_value_o, .status_o, .count_after_o
  );

  min_heap_extract_checker #(.CAPACITY(HeapCap)) checker_i (
    .clk_i, .rst_ni, .start, .busy, .op_i, .value_i,
    .done_o, .popped_value_o, .status_o, .count_after_o,
    .fail_count_o(fail_count), .pending_o(pending_n)
  );

  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [DataW-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      op_i    <= 1'($urandom_range(1));
      value_i <= $urandom;
      @(posedge clk_i);
    end
    start   <= 1'b1;
    op_i    <= op;
    value_i <= value;
    do @(posedge clk_i); while (busy);
    n_items++;
    if (op == OP_LOAD) begin
      n_loads++;
      if (occupancy < HeapCap) occupancy++;
      else n_full++;
    end else begin
      n_pops++;
      if (occupancy > 0) occupancy--;
      else n_empty++;
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_n != 0) @(posedge clk_i);
  endtask

  // non-decreasing words keep heap order on append
  function automatic logic [DataW-1:0] next_ordered_word();
    logic [DataW:0] sum;
    logic [DataW-1:0] step;
    case ($urandom_range(3))
      0:       step = '0;
      1:       step = $urandom_range(1, 15);
      default: step = $urandom >> $urandom_range(12, 31);
    endcase
    sum = {1'b0, ceiling} + {1'b0, step};
    ceiling = sum[DataW] ? '1 : sum[DataW-1:0];
    return ceiling;
  endfunction

  task automatic heap_burst();
    int unsigned fill_n;
    int unsigned drain_n;
    if (occupancy == 0) begin
      case ($urandom_range(3))
        0:       ceiling = '0;
        1:       ceiling = $urandom;
        2:       ceiling = $urandom >> $urandom_range(31);
        default: ceiling = 32'hFFFF_FF00;
      endcase
    end
    fill_n = ($urandom_range(7) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 20);
    if (fill_n > HeapCap - occupancy) fill_n = HeapCap - occupancy;
    repeat (fill_n) begin
      if ($urandom_range(9) == 0) send_item(OP_LOAD, $urandom);
      else send_item(OP_LOAD, next_ordered_word());
    end
    drain_n = ($urandom_range(3) == 0) ? $urandom_range(0, occupancy)
                                       : occupancy + $urandom_range(0, 2);
    repeat (drain_n) begin
      if ($urandom_range(9) == 0) send_item(OP_LOAD, next_ordered_word());
      send_item(OP_POP, $urandom);
    end
  endtask

  initial begin
    int phase_start;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedScript[i]) send_item(DirectedScript[i][DataW], DirectedScript[i][DataW-1:0]);
    drain_results();

    foreach (IdleMix[p]) begin
      idle_pct    = IdleMix[p];
      phase_start = n_items;
      if (idle_pct == 0) begin
        // fill to capacity, overflow it, then sift from a full tree
        while (occupancy < HeapCap) send_item(OP_LOAD, next_ordered_word());
        repeat (3) send_item(OP_LOAD, $urandom);
        repeat ($urandom_range(20, 40)) send_item(OP_POP, $urandom);
      end
      while (n_items - phase_start < PhaseItems) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(4, 16)) send_item(1'($urandom_range(1)), $urandom);
        end else begin
          heap_burst();
        end
        if ($urandom_range(7) == 0) drain_results();
      end
      drain_results();
    end

    repeat (60) @(posedge clk_i);
    $display("Sent %0d transactions: %0d loads (%0d into a full heap), %0d pops (%0d on empty)",
             n_items, n_loads, n_full, n_pops, n_empty);
    $display("Sender idle mixes of 33, 78 and 0 percent, including a fill to %0d words",
             HeapCap);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
